// ===== sv/agc_pkg.sv =====
`default_nettype none
package agc_pkg;

  localparam int TARGET_BITS   = 15;
  localparam int MAX_GAIN_BITS = 16;
  localparam int GAIN_OUT_BITS = 24;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_ADDR_BITS = 3;

  localparam logic [TARGET_BITS-1:0]   TARGET_RESET   = 15'd180;
  localparam logic [MAX_GAIN_BITS-1:0] MAX_GAIN_RESET = 16'd5120;

  typedef enum logic {
    REG_TARGET   = 1'b0,
    REG_MAX_GAIN = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [TARGET_BITS-1:0]   target;
    logic [MAX_GAIN_BITS-1:0] max_gain;
  } agc_cfg_t;

endpackage
`default_nettype wire

// ===== sv/agc_queue.sv =====
`default_nettype none
module agc_queue #(
  parameter int WIDTH = 36
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic                  full,
  output logic                  empty,
  output logic [WIDTH-1:0]      head
);

  logic [WIDTH-1:0] entry [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/agc_front.sv =====
`default_nettype none
module agc_front #(
  parameter int BIAS_WINDOW_SHIFT = 18,
  parameter int SAMPLE_BITS       = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          accept,
  input  wire logic signed [SAMPLE_BITS-1:0] x_i,
  input  wire logic signed [SAMPLE_BITS-1:0] x_q,
  output logic signed [SAMPLE_BITS+1:0]      d_i,
  output logic signed [SAMPLE_BITS+1:0]      d_q
);

  localparam int BW = SAMPLE_BITS + BIAS_WINDOW_SHIFT + 2;
  localparam int DW = SAMPLE_BITS + 2;
  localparam logic signed [BW-1:0] HALF = BW'(1) <<< (BIAS_WINDOW_SHIFT - 1);

  logic signed [BW-1:0] bias_real;
  logic signed [BW-1:0] bias_imag;
  logic signed [BW-1:0] bias_real_next;
  logic signed [BW-1:0] bias_imag_next;
  logic signed [BW-1:0] est_i;
  logic signed [BW-1:0] est_q;

  always_comb begin
    bias_real_next = bias_real - (bias_real >>> BIAS_WINDOW_SHIFT) + BW'(x_i);
    bias_imag_next = bias_imag - (bias_imag >>> BIAS_WINDOW_SHIFT) + BW'(x_q);
    est_i = (bias_real_next + HALF) >>> BIAS_WINDOW_SHIFT;
    est_q = (bias_imag_next + HALF) >>> BIAS_WINDOW_SHIFT;
    d_i = DW'(BW'(x_i) - est_i);
    d_q = DW'(BW'(x_q) - est_q);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bias_real <= '0;
      bias_imag <= '0;
    end else if (accept) begin
      bias_real <= bias_real_next;
      bias_imag <= bias_imag_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/agc_back.sv =====
`default_nettype none
module agc_back #(
  parameter int AVERAGE_WINDOW_SHIFT = 16,
  parameter int SAMPLE_BITS          = 16,
  parameter int GAIN_FRACTION_BITS   = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire agc_pkg::agc_cfg_t                    cfg,
  input  wire logic                                 q_empty,
  input  wire logic [2*SAMPLE_BITS+3:0]             q_head,
  output logic                                      q_pop,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [SAMPLE_BITS-1:0]             out_i,
  output logic signed [SAMPLE_BITS-1:0]             out_q,
  output logic [GAIN_FRACTION_BITS+7:0]             gain,
  output logic                                      clipped
);
  import agc_pkg::*;

  localparam int DW  = SAMPLE_BITS + 2;
  localparam int M2  = 2 * DW;
  localparam int AW  = SAMPLE_BITS + AVERAGE_WINDOW_SHIFT + 2;
  localparam int GW  = GAIN_FRACTION_BITS + 8;
  localparam int QN  = GW + 1;
  localparam int DVW = TARGET_BITS + AVERAGE_WINDOW_SHIFT + GAIN_FRACTION_BITS;
  localparam int PW  = DW + GW + 1;
  localparam int IT  = (DW > QN) ? DW : QN;
  localparam int CW  = $clog2(IT + 1);
  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (GAIN_FRACTION_BITS - 1);
  localparam logic signed [PW-1:0] HI   = PW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  localparam logic signed [PW-1:0] LO   = -HI - PW'(1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_SQRT = 8'b00000010,
    S_AVG  = 8'b00000100,
    S_DCHK = 8'b00001000,
    S_DIV  = 8'b00010000,
    S_CLMP = 8'b00100000,
    S_MUL  = 8'b01000000,
    S_OUT  = 8'b10000000
  } state_t;

  state_t                 state;
  logic [CW-1:0]          cnt;
  logic signed [DW-1:0]   d_i;
  logic signed [DW-1:0]   d_q;
  logic [M2-1:0]          sq_n;
  logic [DW+1:0]          sq_rem;
  logic [DW-1:0]          sq_root;
  logic [AW-1:0]          avg;
  logic [AW-1:0]          dv_rem;
  logic [QN-1:0]          dv_low;
  logic [QN-1:0]          quot;
  logic [GW-1:0]          cur_gain;
  logic signed [PW-1:0]   prod_i;
  logic signed [PW-1:0]   prod_q;

  logic signed [DW-1:0]   h_i;
  logic signed [DW-1:0]   h_q;
  logic [M2-1:0]          mag2;
  logic [DW+3:0]          sq_t;
  logic [DW+3:0]          sq_trial;
  logic [AW-1:0]          avg_next;
  logic [DVW-1:0]         dvd;
  logic [AW-1:0]          r0;
  logic [AW:0]            dv_t;
  logic [GW-1:0]          limit;
  logic signed [PW-1:0]   r_i;
  logic signed [PW-1:0]   r_q;
  logic signed [SAMPLE_BITS-1:0] s_i;
  logic signed [SAMPLE_BITS-1:0] s_q;
  logic                   c_i;
  logic                   c_q;
  logic                   slot_free;

  always_comb begin
    h_i      = q_head[2*DW-1:DW];
    h_q      = q_head[DW-1:0];
    mag2     = M2'(h_i * h_i) + M2'(h_q * h_q);
    sq_t     = {sq_rem, sq_n[M2-1:M2-2]};
    sq_trial = (DW+4)'({sq_root, 2'b01});
    avg_next = avg - (avg >> AVERAGE_WINDOW_SHIFT) + AW'(sq_root);
    dvd      = {cfg.target, {(AVERAGE_WINDOW_SHIFT + GAIN_FRACTION_BITS){1'b0}}};
    r0       = AW'(dvd[DVW-1:QN]);
    dv_t     = {dv_rem, dv_low[QN-1]};
    limit    = GW'(cfg.max_gain) << (GAIN_FRACTION_BITS - 8);
    r_i      = (prod_i + HALF) >>> GAIN_FRACTION_BITS;
    r_q      = (prod_q + HALF) >>> GAIN_FRACTION_BITS;
    c_i      = (r_i > HI) || (r_i < LO);
    c_q      = (r_q > HI) || (r_q < LO);
    s_i      = (r_i > HI) ? SAMPLE_BITS'(HI) : (r_i < LO) ? SAMPLE_BITS'(LO)
                                                          : SAMPLE_BITS'(r_i);
    s_q      = (r_q > HI) ? SAMPLE_BITS'(HI) : (r_q < LO) ? SAMPLE_BITS'(LO)
                                                          : SAMPLE_BITS'(r_q);
    slot_free = !out_valid || !out_stall;
    q_pop    = (state == S_IDLE) && !q_empty;
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        d_i     <= h_i;
        d_q     <= h_q;
        sq_n    <= mag2;
        sq_rem  <= '0;
        sq_root <= '0;
      end
      S_SQRT: begin
        sq_n <= sq_n << 2;
        if (sq_t >= sq_trial) begin
          sq_rem  <= (DW+2)'(sq_t - sq_trial);
          sq_root <= {sq_root[DW-2:0], 1'b1};
        end else begin
          sq_rem  <= (DW+2)'(sq_t);
          sq_root <= {sq_root[DW-2:0], 1'b0};
        end
      end
      S_DCHK: begin
        dv_rem <= r0;
        dv_low <= dvd[QN-1:0];
        quot   <= '0;
        if ((avg == '0) || (r0 >= avg)) begin
          cur_gain <= limit;
        end
      end
      S_DIV: begin
        dv_low <= dv_low << 1;
        if (dv_t >= {1'b0, avg}) begin
          dv_rem <= AW'(dv_t - {1'b0, avg});
          quot   <= {quot[QN-2:0], 1'b1};
        end else begin
          dv_rem <= AW'(dv_t);
          quot   <= {quot[QN-2:0], 1'b0};
        end
      end
      S_CLMP: begin
        cur_gain <= (quot > QN'(limit)) ? limit : GW'(quot);
      end
      S_MUL: begin
        prod_i <= PW'(d_i) * PW'($signed({1'b0, cur_gain}));
        prod_q <= PW'(d_q) * PW'($signed({1'b0, cur_gain}));
      end
      S_OUT: begin
        if (slot_free) begin
          out_i   <= s_i;
          out_q   <= s_q;
          gain    <= cur_gain;
          clipped <= c_i || c_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
      avg       <= AW'(TARGET_RESET) << AVERAGE_WINDOW_SHIFT;
    end else begin
      if ((state == S_OUT) && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          cnt <= '0;
          if (!q_empty) begin
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          cnt <= cnt + CW'(1);
          if (cnt == CW'(DW - 1)) begin
            state <= S_AVG;
          end
        end
        S_AVG: begin
          avg   <= avg_next;
          state <= S_DCHK;
        end
        S_DCHK: begin
          cnt <= '0;
          if ((avg == '0) || (r0 >= avg)) begin
            state <= S_MUL;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          cnt <= cnt + CW'(1);
          if (cnt == CW'(QN - 1)) begin
            state <= S_CLMP;
          end
        end
        S_CLMP: state <= S_MUL;
        S_MUL:  state <= S_OUT;
        S_OUT: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== sv/complex_agc_with_dc_removal.sv =====
`default_nettype none
// Complex AGC with DC offset removal.
// Input channel: sample_i/sample_q with in_valid/in_stall; a request is taken
// on a rising edge with in_valid high and in_stall low.
// Output channel: out_i, out_q, applied_gain, clipped with out_valid/out_stall;
// one result per input request, in order.
// Configuration: APB-style port, target_amplitude at 0x0, max_gain at 0x4,
// pready always high. Write only while the block is idle; it does not check.
// The front stage removes the DC bias in the accept cycle and writes the
// corrected sample into a two-entry queue; in_stall is high while it is full.
// The back stage runs one sample at a time: pop and square, bit-pair square
// root, one average update, one range check, a restoring divide and one clamp
// (both skipped when the gain saturates or the average is zero), multiply
// and round. It pops the next sample only after its last result has been
// written to the output register.
// A result waits in the output register while out_stall is high; the back
// stage holds its next result until the register drains, while the queue
// keeps taking requests.
// Reset clears the bias, loads the average with 180 in Q18.16, restores the
// register defaults and empties the queue and output.
module complex_agc_with_dc_removal #(
  parameter int BIAS_WINDOW_SHIFT    = 18,
  parameter int AVERAGE_WINDOW_SHIFT = 16,
  parameter int SAMPLE_BITS          = 16,
  parameter int GAIN_FRACTION_BITS   = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0]          sample_i,
  input  wire logic signed [SAMPLE_BITS-1:0]          sample_q,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic signed [SAMPLE_BITS-1:0]               out_i,
  output logic signed [SAMPLE_BITS-1:0]               out_q,
  output logic [agc_pkg::GAIN_OUT_BITS-1:0]           applied_gain,
  output logic                                        clipped,
  input  wire logic                                   psel,
  input  wire logic                                   penable,
  input  wire logic                                   pwrite,
  input  wire logic [agc_pkg::CFG_ADDR_BITS-1:0]      paddr,
  input  wire logic [agc_pkg::CFG_DATA_BITS-1:0]      pwdata,
  output logic [agc_pkg::CFG_DATA_BITS-1:0]           prdata,
  output logic                                        pready
);
  import agc_pkg::*;

  localparam int DW = SAMPLE_BITS + 2;
  localparam int GW = GAIN_FRACTION_BITS + 8;

  agc_cfg_t             cfg;
  logic                 accept;
  logic                 q_full;
  logic                 q_empty;
  logic                 q_pop;
  logic [2*DW-1:0]      q_head;
  logic signed [DW-1:0] d_i;
  logic signed [DW-1:0] d_q;
  logic [GW-1:0]        gain;
  reg_index_t           idx;

  assign pready       = 1'b1;
  assign in_stall     = q_full;
  assign accept       = in_valid && !q_full;
  assign applied_gain = GAIN_OUT_BITS'(gain);
  assign idx          = reg_index_t'(paddr[2]);

  always_comb begin
    unique case (idx)
      REG_TARGET:   prdata = CFG_DATA_BITS'(cfg.target);
      REG_MAX_GAIN: prdata = CFG_DATA_BITS'(cfg.max_gain);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target   <= TARGET_RESET;
      cfg.max_gain <= MAX_GAIN_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (idx)
        REG_TARGET:   cfg.target   <= pwdata[TARGET_BITS-1:0];
        REG_MAX_GAIN: cfg.max_gain <= pwdata[MAX_GAIN_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  agc_front #(
    .BIAS_WINDOW_SHIFT(BIAS_WINDOW_SHIFT),
    .SAMPLE_BITS      (SAMPLE_BITS)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .accept(accept),
    .x_i   (sample_i),
    .x_q   (sample_q),
    .d_i   (d_i),
    .d_q   (d_q)
  );

  agc_queue #(
    .WIDTH(2 * DW)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_data({d_i, d_q}),
    .pop      (q_pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (q_head)
  );

  agc_back #(
    .AVERAGE_WINDOW_SHIFT(AVERAGE_WINDOW_SHIFT),
    .SAMPLE_BITS         (SAMPLE_BITS),
    .GAIN_FRACTION_BITS  (GAIN_FRACTION_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_i    (out_i),
    .out_q    (out_q),
    .gain     (gain),
    .clipped  (clipped)
  );

endmodule
`default_nettype wire

// ===== sv/agc_chk.sv =====
`default_nettype none
module agc_chk #(
  parameter int SAMPLE_BITS = 16
) (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic signed [SAMPLE_BITS-1:0] out_i,
  input wire logic signed [SAMPLE_BITS-1:0] out_q,
  input wire logic [23:0]                   applied_gain,
  input wire logic                          clipped
);

  localparam logic signed [SAMPLE_BITS-1:0] HI = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] LO = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_i) && $stable(out_q))
    else $error("stalled result changed");

  a_clip_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && clipped |->
      (out_i == HI) || (out_i == LO) || (out_q == HI) || (out_q == LO))
    else $error("clip flag without saturated component");

  a_zero_gain: assert property (@(posedge clk) disable iff (rst)
    out_valid && (applied_gain == 24'd0) |-> (out_i == '0) && (out_q == '0) && !clipped)
    else $error("non-zero output with zero gain");

endmodule

bind complex_agc_with_dc_removal agc_chk #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_agc_chk (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_i       (out_i),
  .out_q       (out_q),
  .applied_gain(applied_gain),
  .clipped     (clipped)
);
`default_nettype wire
